// File: rtl/qts_pkg.sv
// shared types and constants for the quintic trajectory sampler
`timescale 1ns / 1ps
package qts_pkg;

  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int DIV_W      = 72;
  localparam int DIV_BITS   = 8;
  localparam int DIV_STEPS  = DIV_W / DIV_BITS;

  localparam logic [2:0] HORNER_FIRST = 3'd4;
  localparam logic [2:0] HORNER_LAST  = 3'd0;

  typedef struct packed {
    logic signed [31:0] start_position;
    logic signed [31:0] start_velocity;
    logic signed [31:0] start_accel;
    logic signed [31:0] end_position;
    logic [15:0]        move_duration;
    logic [6:0]         point_count;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         sample_index;
    logic signed [31:0] sample_position;
    logic               last_sample;
    logic               bad_request;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       prep1;
    logic       prep2;
    logic       prep3;
    logic       coef;
    logic       samp_init;
    logic       mul;
    logic       add;
    logic       emit;
    logic       emit_bad;
    logic       next_k;
    logic [2:0] coef_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic in_bad;
    logic div_done;
    logic last_k;
  } dp_status_t;

endpackage

// File: rtl/qts_div.sv
// multi-cycle unsigned divider, eight quotient bits per cycle, small divisor
`timescale 1ns / 1ps
module qts_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [qts_pkg::DIV_W-1:0] dividend,
  input  logic [qts_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [qts_pkg::DIV_W-1:0] quotient
);

  logic                      busy;
  logic [3:0]                cnt;
  logic [qts_pkg::CNT_W-1:0] rem;
  logic [qts_pkg::CNT_W-1:0] dvs;
  logic [qts_pkg::DIV_W-1:0] quo;
  logic [qts_pkg::CNT_W-1:0] rem_next;
  logic [qts_pkg::DIV_W-1:0] quo_next;

  always_comb begin
    logic [qts_pkg::CNT_W-1:0] t;
    logic                      ge;
    rem_next = rem;
    quo_next = quo;
    for (int j = 0; j < qts_pkg::DIV_BITS; j++) begin
      // remainder stays below the divisor, so its top bit is free for the shift
      t        = {rem_next[qts_pkg::CNT_W-2:0], quo_next[qts_pkg::DIV_W-1]};
      ge       = (t >= dvs);
      quo_next = {quo_next[qts_pkg::DIV_W-2:0], ge};
      rem_next = ge ? (t - dvs) : t;
    end
  end

  assign done     = busy && (cnt == 4'(qts_pkg::DIV_STEPS - 1));
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

// File: rtl/qts_dp.sv
// datapath: coefficient fit, horner evaluation and output register
`timescale 1ns / 1ps
module qts_dp (
  input  logic                clk,
  input  logic                rst,
  input  qts_pkg::in_item_t   in_data,
  input  qts_pkg::dp_cmd_t    cmd,
  output qts_pkg::dp_status_t status,
  output qts_pkg::out_item_t  out_data
);

  logic signed [31:0]        p0, v0, a0, pf;
  logic [15:0]               tdur;
  logic [qts_pkg::CNT_W-1:0] n;
  logic [qts_pkg::IDX_W-1:0] k;
  logic signed [48:0]        vprod;
  logic [47:0]               aprod1;
  logic [63:0]               aprod2;
  logic signed [63:0]        vt, ah, h;
  logic signed [63:0]        c0, c1, c2, c3, c4, c5;
  logic signed [63:0]        acc;
  logic                      neg;
  qts_pkg::out_item_t        out_reg;

  logic [31:0]               amag;
  logic [48:0]               vmag;
  logic signed [63:0]        vq;
  logic signed [63:0]        aq;
  logic signed [32:0]        diff;
  logic [qts_pkg::CNT_W-1:0] m;
  logic [63:0]               accmag;
  logic [qts_pkg::DIV_W-1:0] dividend;
  logic                      div_done;
  logic [qts_pkg::DIV_W-1:0] quotient;
  logic signed [63:0]        qv;
  logic signed [63:0]        csel;
  logic [64:0]               rmag;
  logic signed [64:0]        rs;
  logic signed [31:0]        sat;

  assign amag = a0[31] ? (~a0 + 32'd1) : a0;
  assign vmag = vprod[48] ? 49'(-vprod) : 49'(vprod);
  assign vq   = $signed(64'((vmag + 49'd8) >> 4));
  assign aq   = $signed(64'((aprod2 + 64'h10000) >> 17));
  assign diff = 33'(pf) - 33'(p0);

  assign m        = {1'b0, k} + 7'd1;
  assign accmag   = acc[63] ? 64'(-acc) : 64'(acc);
  assign dividend = 72'(accmag) * 72'(m) + 72'(n >> 1);
  assign qv       = $signed(quotient[63:0]);

  always_comb begin
    case (cmd.coef_sel)
      3'd0:    csel = c0;
      3'd1:    csel = c1;
      3'd2:    csel = c2;
      3'd3:    csel = c3;
      3'd4:    csel = c4;
      3'd5:    csel = c5;
      default: csel = c0;
    endcase
  end

  // final scale from 2^-24 to 2^-16 with rounding, then clamp to 32 bits
  always_comb begin
    rmag = acc[63] ? 65'(-acc) : 65'(acc);
    rs   = $signed((rmag + 65'd128) >> 8);
    if (acc[63]) rs = -rs;
    if (rs > 65'sh7fffffff)        sat = 32'sh7fffffff;
    else if (rs < -65'sh80000000)  sat = 32'sh80000000;
    else                           sat = rs[31:0];
  end

  qts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mul),
    .dividend (dividend),
    .divisor  (n),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p0   <= in_data.start_position;
      v0   <= in_data.start_velocity;
      a0   <= in_data.start_accel;
      pf   <= in_data.end_position;
      tdur <= in_data.move_duration;
      n    <= (in_data.point_count > 7'(qts_pkg::MAX_POINTS)) ?
              7'(qts_pkg::MAX_POINTS) : in_data.point_count;
      k    <= '0;
    end
    if (cmd.next_k) k <= k + 6'd1;
    if (cmd.prep1) begin
      vprod  <= v0 * $signed({1'b0, tdur});
      aprod1 <= 48'(amag) * 48'(tdur);
    end
    if (cmd.prep2) begin
      vt     <= vprod[48] ? -vq : vq;
      aprod2 <= 64'(aprod1) * 64'(tdur);
    end
    if (cmd.prep3) begin
      ah <= a0[31] ? -aq : aq;
      h  <= 64'(diff) <<< 8;
      c0 <= 64'(p0) <<< 8;
    end
    if (cmd.coef) begin
      c1 <= vt;
      c2 <= ah;
      c3 <= (h <<< 3) + (h <<< 1) - (vt <<< 2) - (vt <<< 1) - (ah <<< 1) - ah;
      c4 <= h - (h <<< 4) + (vt <<< 3) + (ah <<< 1) + ah;
      c5 <= (h <<< 2) + (h <<< 1) - (vt <<< 1) - vt - ah;
    end
    if (cmd.samp_init) acc <= c5;
    if (cmd.mul)       neg <= acc[63];
    if (cmd.add)       acc <= (neg ? -qv : qv) + csel;
    if (cmd.emit) begin
      out_reg.sample_index    <= k;
      out_reg.sample_position <= sat;
      out_reg.last_sample     <= status.last_k;
      out_reg.bad_request     <= 1'b0;
    end
    if (cmd.emit_bad) begin
      // an error request counts as a one-point move so the controller sees its last sample
      k                       <= '0;
      n                       <= 7'd1;
      out_reg.sample_index    <= '0;
      out_reg.sample_position <= '0;
      out_reg.last_sample     <= 1'b1;
      out_reg.bad_request     <= 1'b1;
    end
  end

  assign status.in_bad   = (in_data.move_duration == 16'd0) || (in_data.point_count == 7'd0);
  assign status.div_done = div_done;
  assign status.last_k   = ({1'b0, k} == (n - 7'd1));
  assign out_data        = out_reg;

endmodule

// File: rtl/qts_ctrl.sv
// controller: sequences the fit, the horner steps and the sample handshake
`timescale 1ns / 1ps
module qts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  qts_pkg::dp_status_t status,
  output qts_pkg::dp_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_PREP1 = 11'b00000000010,
    S_PREP2 = 11'b00000000100,
    S_PREP3 = 11'b00000001000,
    S_COEF  = 11'b00000010000,
    S_SINIT = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_ADD   = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] sel, sel_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next   = state;
    sel_next     = sel;
    cmd          = '0;
    cmd.coef_sel = sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.in_bad) begin
            cmd.emit_bad = 1'b1;
            state_next   = S_OUT;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_PREP1;
          end
        end
      end
      S_PREP1: begin
        cmd.prep1  = 1'b1;
        state_next = S_PREP2;
      end
      S_PREP2: begin
        cmd.prep2  = 1'b1;
        state_next = S_PREP3;
      end
      S_PREP3: begin
        cmd.prep3  = 1'b1;
        state_next = S_COEF;
      end
      S_COEF: begin
        cmd.coef   = 1'b1;
        state_next = S_SINIT;
      end
      S_SINIT: begin
        cmd.samp_init = 1'b1;
        sel_next      = qts_pkg::HORNER_FIRST;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (sel == qts_pkg::HORNER_LAST) begin
          state_next = S_FIN;
        end else begin
          sel_next   = sel - 3'd1;
          state_next = S_MUL;
        end
      end
      S_FIN: begin
        cmd.emit   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (status.last_k) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_k = 1'b1;
            state_next = S_SINIT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= qts_pkg::HORNER_LAST;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

endmodule

// File: rtl/quintic_trajectory_sampler.sv
// top level of the quintic trajectory sampler
`timescale 1ns / 1ps
// One request describes one axis of a move and yields point_count position samples
// (at most 64) along a quintic that ends at rest, or a single flagged result when the
// duration or the count is zero. The block works on one request at a time: the fit
// runs through its prep and coefficient states, then each sample takes five horner
// steps, each a multiply and a divide by the point count in a shared divider, and
// then waits out any output stall.
module quintic_trajectory_sampler (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qts_pkg::out_item_t out_data
);

  qts_pkg::dp_cmd_t    cmd;
  qts_pkg::dp_status_t status;

  qts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  qts_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken while a sample is pending");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_request |-> out_data.last_sample &&
    (out_data.sample_index == 6'd0))
    else $error("error result is not a single final sample");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_sample |=> in_ready)
    else $error("block not idle after final sample");

endmodule
